### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of this block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication across reset");

`endif

### sv/fmrt_pkg.sv
// ---------------------------------------------------------------------------
// fmrt_pkg
// Shared constants and types of the floor match and remove table.
// ---------------------------------------------------------------------------
package fmrt_pkg;

    // Table geometry.
    localparam int CAPACITY   = 1024;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int COUNT_BITS = 16;
    localparam int VALUE_W    = 30;
    localparam int WORD_W     = COUNT_BITS + VALUE_W;

    // Highest copy count an entry can hold.
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Action codes of an input word.
    localparam logic ACTION_LOAD  = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_LOAD_OK  = 2'd0,
        STATUS_LOAD_REJ = 2'd1,
        STATUS_MATCH    = 2'd2,
        STATUS_NONE     = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    // One table entry as stored in memory. A zero count marks a free entry.
    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [VALUE_W-1:0]    value;
    } t_entry;

endpackage

### sv/fmrt_ram.sv
// ---------------------------------------------------------------------------
// fmrt_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ---------------------------------------------------------------------------
module fmrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/floor_match_and_remove_table.sv
// ---------------------------------------------------------------------------
// floor_match_and_remove_table
// Bounded multiset of 30-bit values kept as (value, count) entries in one
// RAM. A load adds one copy (rejected when saturated or full), a query
// removes one copy of the largest stored value not above the query value.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Word fields
//  --------+-----------+--------------------+---------------------------------
//  input   | in        | i_valid / o_stall  | i_action, i_value
//  result  | out       | o_valid / i_stall  | o_status, o_matched_value
//
// Every word is handled by one pass over all CAPACITY entries through the
// single RAM read port, one entry per cycle, then a write-back. The result
// word is registered at the write-back; the next word can be taken once the
// block is back in idle, not before the last word is written back.
// After reset a clearing pass over all CAPACITY entries zeroes every entry;
// no word is accepted during it.
// One result waits in the output register while the next word is taken; a
// stalled result holds the write-back of the following word.
// ---------------------------------------------------------------------------
module floor_match_and_remove_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_action,
    input  logic [fmrt_pkg::VALUE_W-1:0] i_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_status,
    output logic [fmrt_pkg::VALUE_W-1:0] o_matched_value
);

    localparam int AW = fmrt_pkg::ADDR_W;
    localparam int CW = fmrt_pkg::COUNT_BITS;
    localparam int VW = fmrt_pkg::VALUE_W;
    localparam logic [AW:0]   CAP_EXT  = (AW + 1)'(fmrt_pkg::CAPACITY);
    localparam logic [AW-1:0] LAST_IDX = AW'(fmrt_pkg::CAPACITY - 1);

    fmrt_pkg::t_state r_state, n_state;

    // Scan control.
    logic [AW:0]   r_rd_idx, n_rd_idx;
    logic          r_dv;
    logic [AW-1:0] r_dv_idx;

    // Current word.
    logic          r_action;
    logic [VW-1:0] r_value;

    // Scan results.
    logic          r_found, n_found;
    logic [AW-1:0] r_best_idx, n_best_idx;
    logic [VW-1:0] r_best_val, n_best_val;
    logic [CW-1:0] r_best_cnt, n_best_cnt;
    logic          r_free_found, n_free_found;
    logic [AW-1:0] r_free_idx, n_free_idx;

    // Output register.
    logic              r_out_valid;
    fmrt_pkg::t_status r_status;
    logic [VW-1:0]     r_match;

    // Memory port signals.
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    fmrt_pkg::t_entry w_wdata;
    logic [AW-1:0]    w_raddr;
    fmrt_pkg::t_entry w_rdata;
    logic             w_rd_issue;

    // Commit signals.
    logic              w_accept;
    logic              w_commit_go;
    fmrt_pkg::t_status w_status;
    logic [VW-1:0]     w_match;

    fmrt_ram #(
        .WIDTH (fmrt_pkg::WORD_W),
        .DEPTH (fmrt_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_accept    = i_valid && !o_stall;
    assign w_commit_go = (r_state == fmrt_pkg::S_COMMIT) && (!r_out_valid || !i_stall);
    assign w_rd_issue  = (r_state == fmrt_pkg::S_SCAN) && (r_rd_idx < CAP_EXT);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            fmrt_pkg::S_CLEAR: begin
                if (r_rd_idx[AW-1:0] == LAST_IDX) n_state = fmrt_pkg::S_IDLE;
            end
            fmrt_pkg::S_IDLE: begin
                if (i_valid) n_state = fmrt_pkg::S_SCAN;
            end
            fmrt_pkg::S_SCAN: begin
                if (r_dv && (r_dv_idx == LAST_IDX)) n_state = fmrt_pkg::S_COMMIT;
            end
            fmrt_pkg::S_COMMIT: begin
                if (w_commit_go) n_state = fmrt_pkg::S_IDLE;
            end
            default: n_state = fmrt_pkg::S_CLEAR;
        endcase
    end

    // Memory access and result of the write-back.
    always_comb begin
        w_we     = 1'b0;
        w_waddr  = r_rd_idx[AW-1:0];
        w_wdata  = '0;
        w_raddr  = r_rd_idx[AW-1:0];
        w_status = fmrt_pkg::STATUS_NONE;
        w_match  = '0;
        n_rd_idx = r_rd_idx;
        case (r_state)
            fmrt_pkg::S_CLEAR: begin
                w_we     = 1'b1;
                n_rd_idx = r_rd_idx + 1'b1;
            end
            fmrt_pkg::S_IDLE: begin
                n_rd_idx = '0;
            end
            fmrt_pkg::S_SCAN: begin
                if (w_rd_issue) n_rd_idx = r_rd_idx + 1'b1;
            end
            fmrt_pkg::S_COMMIT: begin
                if (r_action == fmrt_pkg::ACTION_QUERY) begin
                    // Remove one copy; a count that drops to zero frees it.
                    if (r_found) begin
                        w_we          = w_commit_go;
                        w_waddr       = r_best_idx;
                        w_wdata.count = r_best_cnt - CW'(1);
                        w_wdata.value = r_best_val;
                        w_status      = fmrt_pkg::STATUS_MATCH;
                        w_match       = r_best_val;
                    end
                end else if (r_found) begin
                    // Value already held: bump its count unless saturated.
                    if (r_best_cnt == fmrt_pkg::COUNT_MAX) begin
                        w_status = fmrt_pkg::STATUS_LOAD_REJ;
                    end else begin
                        w_we          = w_commit_go;
                        w_waddr       = r_best_idx;
                        w_wdata.count = r_best_cnt + CW'(1);
                        w_wdata.value = r_best_val;
                        w_status      = fmrt_pkg::STATUS_LOAD_OK;
                    end
                end else if (r_free_found) begin
                    // New value goes to the lowest free entry.
                    w_we          = w_commit_go;
                    w_waddr       = r_free_idx;
                    w_wdata.count = CW'(1);
                    w_wdata.value = r_value;
                    w_status      = fmrt_pkg::STATUS_LOAD_OK;
                end else begin
                    w_status = fmrt_pkg::STATUS_LOAD_REJ;
                end
            end
            default: begin
                n_rd_idx = '0;
            end
        endcase
    end

    // Per-entry scan update on each word read back from memory.
    always_comb begin
        n_found      = r_found;
        n_best_idx   = r_best_idx;
        n_best_val   = r_best_val;
        n_best_cnt   = r_best_cnt;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        if (w_accept) begin
            n_found      = 1'b0;
            n_free_found = 1'b0;
        end else if (r_dv) begin
            if (r_action == fmrt_pkg::ACTION_QUERY) begin
                if ((w_rdata.count != '0) && (w_rdata.value <= r_value)
                        && (!r_found || (w_rdata.value > r_best_val))) begin
                    n_found    = 1'b1;
                    n_best_idx = r_dv_idx;
                    n_best_val = w_rdata.value;
                    n_best_cnt = w_rdata.count;
                end
            end else begin
                if ((w_rdata.count != '0) && (w_rdata.value == r_value) && !r_found) begin
                    n_found    = 1'b1;
                    n_best_idx = r_dv_idx;
                    n_best_val = w_rdata.value;
                    n_best_cnt = w_rdata.count;
                end
                if ((w_rdata.count == '0) && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_dv_idx;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fmrt_pkg::S_CLEAR;
            r_rd_idx    <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_idx <= n_rd_idx;
            r_dv     <= w_rd_issue;
            if (w_commit_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_dv_idx     <= r_rd_idx[AW-1:0];
        r_found      <= n_found;
        r_best_idx   <= n_best_idx;
        r_best_val   <= n_best_val;
        r_best_cnt   <= n_best_cnt;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        if (w_accept) begin
            r_action <= i_action;
            r_value  <= i_value;
        end
        if (w_commit_go) begin
            r_status <= w_status;
            r_match  <= w_match;
        end
    end

    assign o_stall         = (r_state != fmrt_pkg::S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_matched_value = r_match;

endmodule

### sv/fmrt_checker.sv
// ---------------------------------------------------------------------------
// fmrt_props
// Port-level checks of the floor match and remove table, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fmrt_props (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [1:0]                   o_status,
    input logic [fmrt_pkg::VALUE_W-1:0] o_matched_value
);

    logic [fmrt_pkg::VALUE_W+1:0] w_out_word;
    logic                         w_load_status;

    // Whole result word, and whether it reports a load.
    assign w_out_word    = {o_status, o_matched_value};
    assign w_load_status = o_status inside {fmrt_pkg::STATUS_LOAD_OK, fmrt_pkg::STATUS_LOAD_REJ};

    // A stalled result word holds.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(w_out_word))

    // An accepted word sets the block busy.
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // Load results never carry a matched value.
    `ASSERT_SAME(a_load_no_match, i_clk, i_rst_n, o_valid && w_load_status, o_matched_value == '0)

    // Reset starts the clearing pass with no result pending.
    `ASSERT_NEXT_ALWAYS(a_reset_clear, i_clk, !i_rst_n, o_stall && !o_valid)

endmodule

bind floor_match_and_remove_table fmrt_props u_fmrt_props (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_status        (o_status),
    .o_matched_value (o_matched_value)
);
